[sv/sssr_pkg.sv]
`default_nettype none
package sssr_pkg;

  localparam int unsigned GainW   = 24;
  localparam int unsigned RawW    = 16;
  localparam int unsigned ProdW   = GainW + RawW;
  localparam int unsigned TargetW = 5;
  localparam int unsigned ErrW    = ProdW + 2;
  localparam int unsigned SpW     = 16;
  localparam int unsigned StepW   = 11;

  localparam logic [GainW-1:0] GAIN_RESET = 24'd65536;
  localparam logic [7:0]       LEAD_BYTE  = 8'h3E;

  localparam logic [7:0] CODE_RESET = 8'h46;  // 'F'
  localparam logic [7:0] CODE_T3    = 8'h45;  // 'E'
  localparam logic [7:0] CODE_T6    = 8'h44;  // 'D'
  localparam logic [7:0] CODE_T9    = 8'h42;  // 'B'
  localparam logic [7:0] CODE_T12   = 8'h37;  // '7'
  localparam logic [7:0] CODE_T15   = 8'h33;  // '3'
  localparam logic [7:0] CODE_T20   = 8'h43;  // 'C'

  localparam logic [SpW-1:0] SP_MAX   = 16'd48000;
  localparam logic [SpW-1:0] SP_RESET = 16'd16000;

  // Band edges on the Q16 error; fractional edges rounded away from zero.
  localparam logic signed [ErrW-1:0] EDGE_UP3 = 42'sd589824;
  localparam logic signed [ErrW-1:0] EDGE_UP2 = 42'sd196608;
  localparam logic signed [ErrW-1:0] EDGE_UP1 = 42'sd52429;
  localparam logic signed [ErrW-1:0] EDGE_UP0 = 42'sd32768;
  localparam logic signed [ErrW-1:0] EDGE_DN3 = -42'sd589824;
  localparam logic signed [ErrW-1:0] EDGE_DN2 = -42'sd196608;
  localparam logic signed [ErrW-1:0] EDGE_DN1 = -42'sd52429;
  localparam logic signed [ErrW-1:0] EDGE_DN0 = -42'sd32768;

  localparam logic [StepW-1:0] STEP_UP3 = 11'd1000;
  localparam logic [StepW-1:0] STEP_UP2 = 11'd500;
  localparam logic [StepW-1:0] STEP_UP1 = 11'd100;
  localparam logic [StepW-1:0] STEP_UP0 = 11'd25;
  localparam logic [StepW-1:0] STEP_DN3 = 11'd1000;
  localparam logic [StepW-1:0] STEP_DN2 = 11'd250;
  localparam logic [StepW-1:0] STEP_DN1 = 11'd50;
  localparam logic [StepW-1:0] STEP_DN0 = 11'd25;

  typedef enum logic {
    KIND_ADJUST = 1'b0,
    KIND_RESET  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [TargetW-1:0] target;
    logic [ProdW-1:0]   measured;
  } cmd_t;

  function automatic logic [TargetW-1:0] target_for_code(input logic [7:0] code);
    logic [TargetW-1:0] t;
    case (code)
      CODE_T3:  t = 5'd3;
      CODE_T6:  t = 5'd6;
      CODE_T9:  t = 5'd9;
      CODE_T12: t = 5'd12;
      CODE_T15: t = 5'd15;
      CODE_T20: t = 5'd20;
      default:  t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[sv/sssr_front.sv]
`default_nettype none
module sssr_front import sssr_pkg::*; (
  input  wire logic [7:0]       lead_byte_i,
  input  wire logic [7:0]       speed_code_i,
  input  wire logic [RawW-1:0]  measured_raw_i,
  input  wire logic [GainW-1:0] speed_gain_i,
  input  wire logic             accept_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [TargetW-1:0] target;
  logic               is_reset;

  always_comb begin
    target   = target_for_code(speed_code_i);
    is_reset = (speed_code_i == CODE_RESET);
    // Drop frames with a wrong lead byte or a code that selects nothing.
    push_o   = accept_i && (lead_byte_i == LEAD_BYTE) && (is_reset || (target != '0));
    cmd_o.kind     = is_reset ? KIND_RESET : KIND_ADJUST;
    cmd_o.target   = target;
    cmd_o.measured = ProdW'(measured_raw_i) * ProdW'(speed_gain_i);
  end

endmodule
`default_nettype wire

[sv/sssr_fifo.sv]
`default_nettype none
module sssr_fifo import sssr_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntFull);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule
`default_nettype wire

[sv/sssr_back.sv]
`default_nettype none
module sssr_back import sssr_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire cmd_t           cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [SpW-1:0]      out_setpoint_o
);

  logic [SpW-1:0]          sp_q, sp_d;
  logic                    out_valid_q, out_valid_d;
  logic [SpW-1:0]          out_data_q, out_data_d;
  logic signed [ErrW-1:0]  err;
  logic                    raise, lower;
  logic [StepW-1:0]        step;
  logic [SpW:0]            sum;
  logic [SpW-1:0]          adjusted;

  assign pop_o          = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o    = out_valid_q;
  assign out_setpoint_o = out_data_q;

  always_comb begin
    err = $signed({1'b0, cmd_i.target, 16'b0}) - $signed({2'b00, cmd_i.measured});
    raise = 1'b0;
    lower = 1'b0;
    step  = '0;
    if (err >= EDGE_UP3) begin
      raise = 1'b1; step = STEP_UP3;
    end else if (err >= EDGE_UP2) begin
      raise = 1'b1; step = STEP_UP2;
    end else if (err >= EDGE_UP1) begin
      raise = 1'b1; step = STEP_UP1;
    end else if (err >= EDGE_UP0) begin
      raise = 1'b1; step = STEP_UP0;
    end else if (err <= EDGE_DN3) begin
      lower = 1'b1; step = STEP_DN3;
    end else if (err <= EDGE_DN2) begin
      lower = 1'b1; step = STEP_DN2;
    end else if (err <= EDGE_DN1) begin
      lower = 1'b1; step = STEP_DN1;
    end else if (err <= EDGE_DN0) begin
      lower = 1'b1; step = STEP_DN0;
    end

    sum = {1'b0, sp_q} + (SpW + 1)'(step);
    if (raise) begin
      adjusted = (sum > {1'b0, SP_MAX}) ? SP_MAX : sum[SpW-1:0];
    end else begin
      adjusted = (sp_q < SpW'(step)) ? '0 : sp_q - SpW'(step);
    end

    sp_d        = sp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (pop_o) begin
      if (cmd_i.kind == KIND_RESET) begin
        sp_d        = SP_RESET;
        out_valid_d = 1'b1;
        out_data_d  = SP_RESET;
      end else if (raise || lower) begin
        sp_d        = adjusted;
        out_valid_d = 1'b1;
        out_data_d  = adjusted;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= SP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  a_sp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_MAX)
    else $error("setpoint above limit");

  a_reset_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.kind == KIND_RESET) |=> (out_valid_q && out_data_q == SP_RESET
                                             && sp_q == SP_RESET))
    else $error("reset command did not restore setpoint");

endmodule
`default_nettype wire

[sv/stepped_speed_setpoint_regulator.sv]
// Stepped speed setpoint regulator. Each stream word on s_axis is one command
// frame (lead byte, speed code, raw speed count). Frames whose lead byte is
// not '>' or whose code selects nothing are dropped silently. Code 'F' puts
// the drive setpoint back to 16000 (1.6) and emits it; a target code compares
// the target speed with raw count times speed_gain (unsigned Q8.16) and steps
// the setpoint by one of eight asymmetric amounts, clamped to 0..48000 in
// units of 0.0001. Errors inside the dead zone (-0.5, +0.5 km/h) leave the
// setpoint as is and emit nothing. The block takes one frame per clock while
// the queue is not full: the front end decodes and multiplies in the accept
// cycle and writes a small command queue; the back end pops one command per
// cycle, while its output register is free or being read, into that register.
// The queue depth (QueueDepth) sets how many frames can be absorbed while
// m_axis is stalled. Write speed_gain only while no frame is in flight.
`default_nettype none
module stepped_speed_setpoint_regulator import sssr_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // speed_gain register write
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [GainW-1:0]  cfg_data_i,
  // command frames
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [31:0]       s_axis_tdata,  // [7:0] lead_byte, [15:8] speed_code,
                                                // [31:16] measured_raw
  // setpoint results
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [15:0]            m_axis_tdata   // [15:0] setpoint
);

  logic [GainW-1:0] gain_q;
  logic             push, pop, q_full, q_valid;
  cmd_t             push_cmd, pop_cmd;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  // Hold off new frames only while the queue is full.
  assign s_axis_tready = !q_full;

  sssr_front u_front (
    .lead_byte_i    (s_axis_tdata[7:0]),
    .speed_code_i   (s_axis_tdata[15:8]),
    .measured_raw_i (s_axis_tdata[31:16]),
    .speed_gain_i   (gain_q),
    .accept_i       (s_axis_tvalid && s_axis_tready),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  sssr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_cmd)
  );

  sssr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (pop_cmd),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_setpoint_o (m_axis_tdata)
  );

endmodule
`default_nettype wire
